[src/fss_pkg.sv]
package fss_pkg;

  localparam int unsigned NumFeat    = 16;
  localparam int unsigned FeatW      = 4;
  localparam int unsigned CntW       = 5;
  localparam int unsigned TallyW     = 16;
  localparam logic [TallyW-1:0] MaxSamples = 16'hFFFF;
  localparam logic [31:0] OneQ16     = 32'h0001_0000;

  typedef enum logic [1:0] {
    MODE_FIT     = 2'd0,
    MODE_XFORM   = 2'd1,
    MODE_INV     = 2'd2,
    MODE_INV_STD = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO_SD = 2'd1,
    ST_SAT     = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_MUL,
    S_ACC_UPD,
    S_FIT_START,
    S_FIT_MEAN,
    S_FIT_MSQ,
    S_FIT_MUL,
    S_FIT_VAR,
    S_FIT_SQRT,
    S_XF_START,
    S_XF_DIV,
    S_INV_MUL,
    S_INV_RND,
    S_EMIT
  } state_e;

  // classified input beat, front to back
  typedef struct packed {
    mode_e             mode;
    logic              fit_end;
    logic              acc_en;
    logic [FeatW-1:0]  feature;
    logic [31:0]       value;
  } cmd_t;

  typedef struct packed {
    logic [31:0]      result;
    logic [30:0]      spread;
    logic [FeatW-1:0] column;
    status_e          status;
    logic             final_res;
  } res_t;

endpackage

[src/fss_front.sv]
module fss_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [fss_pkg::CntW-1:0] cnt_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             in_mode_i,
  input  logic [3:0]             in_feature_i,
  input  logic [31:0]            in_value_i,
  input  logic                   in_last_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output fss_pkg::cmd_t          cmd_o
);

  fss_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  fss_pkg::cmd_t cmd_new;
  logic          push, pop;

  always_comb begin
    cmd_new.mode    = fss_pkg::mode_e'(in_mode_i);
    cmd_new.feature = in_feature_i;
    cmd_new.value   = in_value_i;
    cmd_new.fit_end = (cmd_new.mode == fss_pkg::MODE_FIT) && in_last_i;
    cmd_new.acc_en  = ({1'b0, in_feature_i} < cnt_i);
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue overfilled");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && !pop) |=> (count_q == 2'd2)) else $error("full queue lost beat");

endmodule

[src/fss_div.sv]
module fss_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic [63:0] quo_q;
  logic [31:0] rem_q, dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] rem_sh, rem_sub;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[63]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      if (!rem_sub[32]) begin
        rem_q <= rem_sub[31:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end else if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[src/fss_sqrt.sv]
module fss_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] x_q, r_q, bit_q, trial;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;

  // digit-by-digit integer root, two radicand bits per cycle
  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      if (x_q >= trial) begin
        x_q <= x_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end else if (start_i) begin
      x_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

[src/fss_back.sv]
module fss_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [fss_pkg::CntW-1:0] cnt_i,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  fss_pkg::cmd_t            cmd_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output fss_pkg::res_t            out_o
);

  localparam int unsigned NF = fss_pkg::NumFeat;

  fss_pkg::state_e state_q, state_d;
  fss_pkg::cmd_t   cmd_q;
  fss_pkg::res_t   pend_q, out_q;
  logic            out_valid_q, fit_loop_q;
  logic [3:0]      k_q;
  logic [31:0]     mean_q, sd_q;
  logic [63:0]     msq_q, prod_q;
  logic            neg_q;

  logic [63:0]       sum_q  [NF];
  logic [63:0]       sq_q   [NF];
  logic [15:0]       tally_q[NF];
  logic [31:0]       mean_st_q[NF];
  logic [31:0]       dev_st_q [NF];

  logic [3:0]  idx;
  logic [63:0] sum_rd, sum_mag, sq_rd;
  logic [15:0] tally_rd;
  logic [31:0] mean_rd, dev_rd, x_mag, mean_mag;
  logic [31:0] mul_a, mul_b;
  logic        div_start, div_busy, div_done, sqrt_start, sqrt_busy, sqrt_done;
  logic [63:0] div_dvd, quo;
  logic [31:0] div_dvs, root;
  logic        emit_go, last_k;
  logic [32:0] diff, diff_mag;
  logic [63:0] m2, var_w, rnd;
  logic signed [49:0] p50;

  assign idx      = fit_loop_q ? k_q : cmd_q.feature;
  assign sum_rd   = sum_q[idx];
  assign sq_rd    = sq_q[idx];
  assign tally_rd = tally_q[idx];
  assign mean_rd  = mean_st_q[idx];
  assign dev_rd   = dev_st_q[idx];
  assign sum_mag  = sum_rd[63] ? (64'd0 - sum_rd) : sum_rd;
  assign x_mag    = cmd_q.value[31] ? (32'd0 - cmd_q.value) : cmd_q.value;
  assign mean_mag = mean_q[31] ? (32'd0 - mean_q) : mean_q;
  assign last_k   = ({1'b0, k_q} == (cnt_i - 5'd1));
  assign emit_go  = !out_valid_q || out_ready_i;

  assign diff     = {cmd_q.value[31], cmd_q.value} - {mean_rd[31], mean_rd};
  assign diff_mag = diff[32] ? (33'd0 - diff) : diff;
  assign m2       = {16'd0, prod_q[63:16]};
  assign var_w    = (msq_q > m2) ? (msq_q - m2) : 64'd0;
  assign rnd      = prod_q + 64'h8000;

  always_comb begin
    p50 = cmd_q.value[31] ? -$signed({2'b00, rnd[63:16]}) : $signed({2'b00, rnd[63:16]});
    if (cmd_q.mode == fss_pkg::MODE_INV) begin
      p50 = p50 + 50'($signed(mean_rd));
    end
  end

  fss_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_dvd), .divisor_i(div_dvs),
    .busy_o(div_busy), .done_o(div_done), .quotient_o(quo)
  );

  fss_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i(sqrt_start), .radicand_i({var_w[47:0], 16'd0}),
    .busy_o(sqrt_busy), .done_o(sqrt_done), .root_o(root)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fss_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.mode)
            fss_pkg::MODE_FIT:   state_d = fss_pkg::S_ACC_MUL;
            fss_pkg::MODE_XFORM: state_d = fss_pkg::S_XF_START;
            default:             state_d = fss_pkg::S_INV_MUL;
          endcase
        end
      end
      fss_pkg::S_ACC_MUL:   state_d = fss_pkg::S_ACC_UPD;
      fss_pkg::S_ACC_UPD:   state_d = cmd_q.fit_end ? fss_pkg::S_FIT_START : fss_pkg::S_IDLE;
      fss_pkg::S_FIT_START: state_d = (tally_rd == 16'd0) ? fss_pkg::S_EMIT : fss_pkg::S_FIT_MEAN;
      fss_pkg::S_FIT_MEAN:  if (div_done) state_d = fss_pkg::S_FIT_MSQ;
      fss_pkg::S_FIT_MSQ:   if (div_done) state_d = fss_pkg::S_FIT_MUL;
      fss_pkg::S_FIT_MUL:   state_d = fss_pkg::S_FIT_VAR;
      fss_pkg::S_FIT_VAR:   state_d = fss_pkg::S_FIT_SQRT;
      fss_pkg::S_FIT_SQRT:  if (sqrt_done) state_d = fss_pkg::S_EMIT;
      fss_pkg::S_XF_START:  state_d = (dev_rd == 32'd0) ? fss_pkg::S_EMIT : fss_pkg::S_XF_DIV;
      fss_pkg::S_XF_DIV:    if (div_done) state_d = fss_pkg::S_EMIT;
      fss_pkg::S_INV_MUL:   state_d = fss_pkg::S_INV_RND;
      fss_pkg::S_INV_RND:   state_d = fss_pkg::S_EMIT;
      fss_pkg::S_EMIT: begin
        if (emit_go) begin
          state_d = (fit_loop_q && !last_k) ? fss_pkg::S_FIT_START : fss_pkg::S_IDLE;
        end
      end
      default: state_d = fss_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_ready_o = (state_q == fss_pkg::S_IDLE);
    mul_a       = x_mag;
    mul_b       = x_mag;
    div_start   = 1'b0;
    div_dvd     = sum_mag + {49'd0, tally_rd[15:1]};
    div_dvs     = {16'd0, tally_rd};
    sqrt_start  = 1'b0;
    unique case (state_q)
      fss_pkg::S_FIT_START: div_start = (tally_rd != 16'd0);
      fss_pkg::S_FIT_MEAN: begin
        div_start = div_done;
        div_dvd   = sq_rd;
      end
      fss_pkg::S_FIT_MUL: begin
        mul_a = mean_mag;
        mul_b = mean_mag;
      end
      fss_pkg::S_FIT_VAR: sqrt_start = 1'b1;
      fss_pkg::S_XF_START: begin
        div_start = (dev_rd != 32'd0);
        div_dvd   = {15'd0, diff_mag, 16'd0} + {33'd0, dev_rd[31:1]};
        div_dvs   = dev_rd;
      end
      fss_pkg::S_INV_MUL: mul_b = dev_rd;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    if (cmd_ready_o && cmd_valid_i) cmd_q <= cmd_i;
    unique case (state_q)
      fss_pkg::S_FIT_START: begin
        if (tally_rd == 16'd0) begin
          mean_q <= '0;
          sd_q   <= '0;
          pend_q <= '{result: '0, spread: '0, column: k_q,
                      status: fss_pkg::ST_ZERO_SD, final_res: last_k};
        end
      end
      fss_pkg::S_FIT_MEAN: begin
        if (div_done) mean_q <= sum_rd[63] ? (32'd0 - quo[31:0]) : quo[31:0];
      end
      fss_pkg::S_FIT_MSQ: begin
        if (div_done) msq_q <= quo;
      end
      fss_pkg::S_FIT_SQRT: begin
        if (sqrt_done) begin
          sd_q <= root[31] ? 32'h7FFF_FFFF : root;
          pend_q.result    <= mean_q;
          pend_q.spread    <= root[31] ? 31'h7FFF_FFFF : root[30:0];
          pend_q.column    <= k_q;
          pend_q.final_res <= last_k;
          if (root == 32'd0)  pend_q.status <= fss_pkg::ST_ZERO_SD;
          else if (root[31])  pend_q.status <= fss_pkg::ST_SAT;
          else                pend_q.status <= fss_pkg::ST_OK;
        end
      end
      fss_pkg::S_XF_START: begin
        neg_q <= diff[32];
        pend_q <= '{result: '0, spread: '0, column: cmd_q.feature,
                    status: fss_pkg::ST_ZERO_SD, final_res: 1'b1};
      end
      fss_pkg::S_XF_DIV: begin
        if (div_done) begin
          if (neg_q && quo > 64'h8000_0000) begin
            pend_q.result <= 32'h8000_0000;
            pend_q.status <= fss_pkg::ST_SAT;
          end else if (!neg_q && quo > 64'h7FFF_FFFF) begin
            pend_q.result <= 32'h7FFF_FFFF;
            pend_q.status <= fss_pkg::ST_SAT;
          end else begin
            pend_q.result <= neg_q ? (32'd0 - quo[31:0]) : quo[31:0];
            pend_q.status <= fss_pkg::ST_OK;
          end
        end
      end
      fss_pkg::S_INV_RND: begin
        pend_q.spread    <= '0;
        pend_q.column    <= cmd_q.feature;
        pend_q.final_res <= 1'b1;
        if (p50 > 50'sh7FFF_FFFF) begin
          pend_q.result <= 32'h7FFF_FFFF;
          pend_q.status <= fss_pkg::ST_SAT;
        end else if (p50 < -50'sh8000_0000) begin
          pend_q.result <= 32'h8000_0000;
          pend_q.status <= fss_pkg::ST_SAT;
        end else begin
          pend_q.result <= p50[31:0];
          pend_q.status <= fss_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    if (state_q == fss_pkg::S_EMIT && emit_go) out_q <= pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fss_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      fit_loop_q  <= 1'b0;
      k_q         <= '0;
      for (int i = 0; i < NF; i++) begin
        sum_q[i]     <= '0;
        sq_q[i]      <= '0;
        tally_q[i]   <= '0;
        mean_st_q[i] <= '0;
        dev_st_q[i]  <= fss_pkg::OneQ16;
      end
    end else begin
      state_q <= state_d;
      if (state_q == fss_pkg::S_ACC_UPD) begin
        if (cmd_q.acc_en && tally_rd != fss_pkg::MaxSamples) begin
          sum_q[idx]   <= sum_rd + {{32{cmd_q.value[31]}}, cmd_q.value};
          sq_q[idx]    <= sq_rd + {16'd0, prod_q[63:16]};
          tally_q[idx] <= tally_rd + 16'd1;
        end
        if (cmd_q.fit_end) begin
          fit_loop_q <= 1'b1;
          k_q        <= '0;
        end
      end
      if (state_q == fss_pkg::S_EMIT && emit_go) begin
        out_valid_q <= 1'b1;
        if (fit_loop_q) begin
          mean_st_q[k_q] <= mean_q;
          dev_st_q[k_q]  <= sd_q;
          if (last_k) begin
            fit_loop_q <= 1'b0;
            for (int i = 0; i < NF; i++) begin
              sum_q[i]   <= '0;
              sq_q[i]    <= '0;
              tally_q[i] <= '0;
            end
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_sqrt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> !sqrt_busy) else $error("root unit restarted while busy");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fss_pkg::S_FIT_START) |-> ({1'b0, k_q} < cnt_i))
    else $error("fit index past feature count");
  a_fit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fss_pkg::S_EMIT && emit_go && fit_loop_q && last_k)
      |=> (state_q == fss_pkg::S_IDLE && tally_q[0] == 16'd0))
    else $error("fit end left accumulators");

endmodule

[src/feature_standard_scaler.sv]
// Per-feature z-score scaler, signed Q16.16.
// Input stream (s_axis): one beat per value. tuser carries mode (fit, transform,
// inverse, inverse std) and the feature column; tlast ends a fit set.
// Output stream (m_axis): one beat per result; tlast marks the last result of
// the run caused by one input beat.
// Config channel (cfg_*): feature count in use; user must write it only while
// idle (the block does not enforce it); 0 acts as 1, values above 16 act as 16.
// A front stage classifies beats into a two-entry queue; the back engine runs
// them one at a time and drops results into an output register, so a stalled
// receiver holds only that register while the engine finishes the next beat.
// Work per beat, done by the back engine's shared units:
//   fit sample (not last), inverse / inverse std: one 32x32 multiply each;
//   transform: one pass of the radix-2 divider;
//   fit end: per feature in use, two divides plus a 32-step root.
// Reset: mean 0 and std 1.0 for every feature, accumulators cleared,
// feature count 1, queue and output register empty.
module feature_standard_scaler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,     // feature_count
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [5:0]  s_axis_tuser,   // [1:0] mode, [5:2] feature
  input  logic        s_axis_tlast,   // last
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] result, [62:32] spread, [63] zero
  output logic [5:0]  m_axis_tuser,   // [3:0] column, [5:4] status
  output logic        m_axis_tlast    // final_res
);

  logic [fss_pkg::CntW-1:0] feat_cnt_q, cnt_eff;
  logic                     cmd_valid, cmd_ready;
  fss_pkg::cmd_t            cmd;
  fss_pkg::res_t            res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_cnt_q <= 5'd1;
    end else if (cfg_valid_i) begin
      feat_cnt_q <= cfg_data_i;
    end
  end

  // clamp to 1..16
  always_comb begin
    if (feat_cnt_q == 5'd0)         cnt_eff = 5'd1;
    else if (feat_cnt_q > 5'd16)    cnt_eff = 5'd16;
    else                            cnt_eff = feat_cnt_q;
  end

  fss_front u_front (
    .clk_i, .rst_ni,
    .cnt_i        (cnt_eff),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_mode_i    (s_axis_tuser[1:0]),
    .in_feature_i (s_axis_tuser[5:2]),
    .in_value_i   (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  fss_back u_back (
    .clk_i, .rst_ni,
    .cnt_i        (cnt_eff),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign m_axis_tdata = {1'b0, res.spread, res.result};
  assign m_axis_tuser = {res.status, res.column};
  assign m_axis_tlast = res.final_res;

endmodule
